FILE: design/group_sort_dense_relabel_core_assert.svh
// Assertion macros used by the design core.
// Simulation builds get the checks; synthesis builds define SYNTH and get empty bodies.
`ifndef GROUP_SORT_DENSE_RELABEL_CORE_ASSERT_SVH
`define GROUP_SORT_DENSE_RELABEL_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define GSDR_ASSERT_IMP(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSDR_ASSERT_NXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define GSDR_ASSERT_IMP(lbl, clk, rst, cond, prop, msg)
`define GSDR_ASSERT_NXT(lbl, clk, rst, cond, prop, msg)

`endif

`endif

FILE: design/gsdr_pkg.sv
package gsdr_pkg;

   // Fixed widths of the point record fields and of the stream ports.
   localparam int GROUP_W    = 16;
   localparam int COORD_W    = 32;
   localparam int Z_W        = 16;
   localparam int RANK_W     = 6;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 88;

   // One stored point record.
   typedef struct packed {
      logic                  kind;
      logic signed [Z_W-1:0] z;
      logic [COORD_W-1:0]    lon;
      logic [COORD_W-1:0]    lat;
      logic [GROUP_W-1:0]    group_id;
   } rec_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_HEAD,
      ST_SCAN,
      ST_STORE,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

endpackage

FILE: design/group_sort_dense_relabel_core.sv
// Load: one item per cycle while req_tready is high, up to MAX_POINTS records kept.
// Sort: after the last item, one compare per cycle while scanning, in the compare unit,
// bound by the single record memory read port.
// Emit: one result at a time, each held until rsp_tready is high; inputs are held off meanwhile.
// Reset is synchronous and clears the sequencer, count, flag and output valid;
// the record memory is not cleared.
module group_sort_dense_relabel_core #(
   parameter int MAX_POINTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // group_id[15:0], lat_bits[47:16], lon_bits[79:48], z[95:80]
   input  logic [gsdr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[0]
   input  logic [0:0]                        req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rank[5:0], lat_bits[37:6], lon_bits[69:38], z[85:70], overflow[86], zero[87]
   output logic [gsdr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind[0]
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tlast
);
   import gsdr_pkg::*;

   `include "group_sort_dense_relabel_core_assert.svh"

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                overflow_ff, overflow_in;
   logic [AW-1:0]       i_ff, i_in;
   logic [AW-1:0]       j_ff, j_in;
   logic [AW-1:0]       k_ff, k_in;
   rec_type             cur_ff, cur_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [GROUP_W-1:0]  prev_ff, prev_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]   out_rank_ff, out_rank_in;
   logic [COORD_W-1:0]  out_lat_ff, out_lat_in;
   logic [COORD_W-1:0]  out_lon_ff, out_lon_in;
   logic [Z_W-1:0]      out_z_ff, out_z_in;
   logic                out_kind_ff, out_kind_in;
   logic                out_ovf_ff, out_ovf_in;
   logic                out_last_ff, out_last_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   rec_type             wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   rec_type             rd_data;

   logic [CW-1:0]       count_dec;
   logic [AW-1:0]       last_idx;
   rec_type             req_rec;
   logic                req_fire;

   assign count_dec = count_ff - CW'(1);
   assign last_idx  = count_dec[AW-1:0];
   assign req_fire  = req_tvalid && req_tready;

   // Unpack the incoming item into a record.
   always_comb begin
      req_rec.group_id = req_tdata[15:0];
      req_rec.lat      = req_tdata[47:16];
      req_rec.lon      = req_tdata[79:48];
      req_rec.z        = req_tdata[95:80];
      req_rec.kind     = req_tuser[0];
   end

   gsdr_record_ram #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: load, exchange sort with the running record of position i held
   // in cur, then emission with dense ranking.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      rank_in      = rank_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      out_rank_in  = out_rank_ff;
      out_lat_in   = out_lat_ff;
      out_lon_in   = out_lon_ff;
      out_z_in     = out_z_ff;
      out_kind_in  = out_kind_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_rec;
      rd_en        = 1'b0;
      rd_addr      = i_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < CAP) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  i_in = '0;
                  k_in = '0;
                  // A single record needs no sorting.
                  if (count_in == CW'(1)) begin
                     state_in = ST_EMIT_RD;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cur_in   = rd_data;
            j_in     = i_ff + AW'(1);
            rd_en    = 1'b1;
            rd_addr  = i_ff + AW'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Swap: the held record goes to j, the record at j becomes held.
            if (cur_ff.group_id > rd_data.group_id) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            if (j_ff == last_idx) begin
               state_in = ST_STORE;
            end else begin
               j_in    = j_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = j_ff + AW'(1);
            end
         end
         ST_STORE: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = cur_ff;
            if (i_ff + AW'(1) == last_idx) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = ST_FETCH;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            // Dense rank rises by one at each new group.
            if (k_ff == '0) begin
               rank_in = '0;
            end else if (rd_data.group_id != prev_ff) begin
               rank_in = rank_ff + RANK_W'(1);
            end
            prev_in      = rd_data.group_id;
            out_rank_in  = rank_in;
            out_lat_in   = rd_data.lat;
            out_lon_in   = rd_data.lon;
            out_z_in     = rd_data.z;
            out_kind_in  = rd_data.kind;
            out_ovf_in   = overflow_ff;
            out_last_in  = (k_ff == last_idx);
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  k_in     = k_ff + AW'(1);
                  rd_en    = 1'b1;
                  rd_addr  = k_ff + AW'(1);
                  state_in = ST_EMIT_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Indexes and payload registers.
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      rank_ff     <= rank_in;
      prev_ff     <= prev_in;
      out_rank_ff <= out_rank_in;
      out_lat_ff  <= out_lat_in;
      out_lon_ff  <= out_lon_in;
      out_z_ff    <= out_z_in;
      out_kind_ff <= out_kind_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_ovf_ff, out_z_ff, out_lon_ff, out_lat_ff, out_rank_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // Checks on the sequencer.
   `GSDR_ASSERT_IMP(a_no_load_while_emit, clock, reset, req_tready, !rsp_tvalid, "input taken during emission")
   `GSDR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CAP, "record count past capacity")
   `GSDR_ASSERT_IMP(a_scan_order, clock, reset, state_ff == ST_SCAN, j_ff > i_ff && j_ff <= last_idx, "scan index out of range")
   `GSDR_ASSERT_NXT(a_run_end_clears, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, count_ff == '0 && !overflow_ff && req_tready, "run end did not clear state")
   `GSDR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

FILE: design/gsdr_record_ram.sv
module gsdr_record_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  gsdr_pkg::rec_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output gsdr_pkg::rec_type rd_data
);
   import gsdr_pkg::*;

   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   // One write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // One read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
